// ===== hw/rtl/ipv4fwd_pkg.sv =====
// Package with shared types and constants of the IPv4 forwarding block.
`default_nettype none
package ipv4fwd_pkg;
    localparam int MAX_PORTS  = 4;
    localparam int MAX_ROUTES = 16;
    localparam int PORT_W  = $clog2(MAX_PORTS);
    localparam int ROUTE_W = $clog2(MAX_ROUTES);
    localparam int PCNT_W  = $clog2(MAX_PORTS + 1);
    localparam int RCNT_W  = $clog2(MAX_ROUTES + 1);

    typedef enum logic [1:0] {
        ACT_WR_IF    = 2'd0,
        ACT_WR_ROUTE = 2'd1,
        ACT_CLASSIFY = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        DEC_ACK      = 3'd0,
        DEC_DROP     = 3'd1,
        DEC_PORT_UNR = 3'd2,
        DEC_NET_UNR  = 3'd3,
        DEC_HOST_UNR = 3'd4,
        DEC_ECHO     = 3'd5,
        DEC_FWD      = 3'd6,
        DEC_TTL_EXC  = 3'd7
    } decision_t;

    localparam logic REG_IF_COUNT    = 1'b0;
    localparam logic REG_ROUTE_COUNT = 1'b1;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PORTS  = 2'd1,
        ST_ROUTES = 2'd2,
        ST_OUT    = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  entry_index;
        logic [31:0] entry_ip;
        logic [31:0] entry_mask;
        logic [31:0] entry_gateway;
        logic [1:0]  entry_port;
        logic [47:0] entry_mac;
        logic [47:0] pkt_dst_mac;
        logic [31:0] pkt_dst_ip;
        logic [7:0]  pkt_proto;
        logic [7:0]  pkt_icmp_kind;
        logic [7:0]  pkt_ttl;
    } req_t;

    typedef struct packed {
        logic [2:0]  decision;
        logic [1:0]  inbound_port;
        logic [1:0]  outbound_port;
        logic [31:0] next_hop_ip;
        logic [47:0] outbound_mac;
        logic [31:0] reply_src_ip;
        logic [7:0]  new_ttl;
    } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ipv4fwd_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration writes.
`default_nettype none
interface ipv4fwd_req_if;
    import ipv4fwd_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ipv4fwd_rsp_if;
    import ipv4fwd_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ipv4fwd_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ipv4fwd_queue.sv =====
// Two-entry request queue between the intake side and the lookup engine.
`default_nettype none
module ipv4fwd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ipv4fwd_pkg::req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ipv4fwd_pkg::req_t      out_data
);
    import ipv4fwd_pkg::*;

    req_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2) else $error("full queue lost entry");
endmodule
`default_nettype wire

// ===== hw/rtl/ipv4fwd_engine.sv =====
// Lookup engine: table writes, interface scan, route scan and result register.
`default_nettype none
module ipv4fwd_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire ipv4fwd_pkg::req_t               req,
    input  wire logic [ipv4fwd_pkg::PCNT_W-1:0]  nif,
    input  wire logic [ipv4fwd_pkg::RCNT_W-1:0]  nrt,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output ipv4fwd_pkg::rsp_t                    rsp
);
    import ipv4fwd_pkg::*;

    logic [31:0] port_ip_mem   [MAX_PORTS];
    logic [47:0] port_mac_mem  [MAX_PORTS];
    logic [31:0] rt_prefix_mem [MAX_ROUTES];
    logic [31:0] rt_mask_mem   [MAX_ROUTES];
    logic [31:0] rt_gw_mem     [MAX_ROUTES];
    logic [1:0]  rt_port_mem   [MAX_ROUTES];

    state_t state_reg, state_next;
    req_t   cur_reg;
    logic [PCNT_W-1:0] pi_reg;
    logic [RCNT_W-1:0] ri_reg;
    logic        have_in_reg, to_router_reg, matched_reg;
    logic [PORT_W-1:0] in_port_reg;
    logic [31:0] in_ip_reg;
    logic [31:0] best_mask_reg, best_gw_reg;
    logic [1:0]  best_port_reg;
    logic [47:0] out_mac_reg;
    rsp_t        rsp_reg;
    logic        rsp_valid_reg;

    logic take, is_classify, ports_done, routes_done, out_slot_free;
    logic [PORT_W-1:0]  pidx;
    logic [ROUTE_W-1:0] ridx;
    logic        route_hit;
    rsp_t        rsp_comb;
    logic        tcp_udp, host_unr;

    assign out_slot_free = !rsp_valid_reg || rsp_ready;
    assign is_classify = (req.action == ACT_CLASSIFY);
    assign pidx = pi_reg[PORT_W-1:0];
    assign ridx = ri_reg[ROUTE_W-1:0];
    assign ports_done  = (pi_reg >= nif);
    assign routes_done = (ri_reg >= nrt) || to_router_reg;
    assign route_hit = (rt_mask_mem[ridx] & rt_prefix_mem[ridx])
                    == (rt_mask_mem[ridx] & cur_reg.pkt_dst_ip);

    // Writes and ignored actions finish in IDLE when the output slot is free.
    assign req_ready = (state_reg == ST_IDLE) && (is_classify || out_slot_free);
    assign take = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (take && is_classify) state_next = ST_PORTS;
            ST_PORTS:  if (ports_done) state_next = have_in_reg ? ST_ROUTES : ST_OUT;
            ST_ROUTES: if (routes_done) state_next = ST_OUT;
            ST_OUT:    if (out_slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tcp_udp  = (cur_reg.pkt_proto == PROTO_TCP || cur_reg.pkt_proto == PROTO_UDP)
                && to_router_reg;
        host_unr = to_router_reg && (in_ip_reg != cur_reg.pkt_dst_ip);
        rsp_comb = '0;
        if (!have_in_reg)
        begin
            rsp_comb.decision = DEC_DROP;
        end
        else
        begin
            rsp_comb.inbound_port = 2'(in_port_reg);
            if (tcp_udp)
            begin
                rsp_comb.decision = DEC_PORT_UNR;
                rsp_comb.reply_src_ip = cur_reg.pkt_dst_ip;
            end
            else if (!to_router_reg && !matched_reg)
            begin
                rsp_comb.decision = DEC_NET_UNR;
                rsp_comb.reply_src_ip = cur_reg.pkt_dst_ip;
            end
            else if (host_unr)
            begin
                rsp_comb.decision = DEC_HOST_UNR;
                rsp_comb.reply_src_ip = cur_reg.pkt_dst_ip;
            end
            else if (to_router_reg && cur_reg.pkt_proto == PROTO_ICMP
                     && cur_reg.pkt_icmp_kind == ICMP_ECHO_REQ)
            begin
                rsp_comb.decision = DEC_ECHO;
                rsp_comb.reply_src_ip = in_ip_reg;
            end
            else if (!to_router_reg)
            begin
                if (cur_reg.pkt_ttl <= 8'd1)
                begin
                    rsp_comb.decision = DEC_TTL_EXC;
                    rsp_comb.reply_src_ip = cur_reg.pkt_dst_ip;
                end
                else
                begin
                    rsp_comb.decision = DEC_FWD;
                    rsp_comb.outbound_port = best_port_reg;
                    rsp_comb.next_hop_ip = (best_gw_reg != 32'd0) ? best_gw_reg
                                                                  : cur_reg.pkt_dst_ip;
                    rsp_comb.outbound_mac = out_mac_reg;
                    rsp_comb.new_ttl = cur_reg.pkt_ttl - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= req;
            if (req.action == ACT_WR_IF && 32'(req.entry_index) < MAX_PORTS)
            begin
                port_ip_mem[PORT_W'(req.entry_index)]  <= req.entry_ip;
                port_mac_mem[PORT_W'(req.entry_index)] <= req.entry_mac;
            end
            if (req.action == ACT_WR_ROUTE && 32'(req.entry_index) < MAX_ROUTES)
            begin
                rt_prefix_mem[ROUTE_W'(req.entry_index)] <= req.entry_ip;
                rt_mask_mem[ROUTE_W'(req.entry_index)]   <= req.entry_mask;
                rt_gw_mem[ROUTE_W'(req.entry_index)]     <= req.entry_gateway;
                rt_port_mem[ROUTE_W'(req.entry_index)]   <= req.entry_port;
            end
        end
        if (state_reg == ST_IDLE)
        begin
            pi_reg <= '0;
            ri_reg <= '0;
            have_in_reg <= 1'b0;
            to_router_reg <= 1'b0;
            matched_reg <= 1'b0;
            in_port_reg <= '0;
            best_mask_reg <= '0;
            best_port_reg <= '0;
            best_gw_reg <= '0;
        end
        else if (state_reg == ST_PORTS && !ports_done)
        begin
            pi_reg <= pi_reg + PCNT_W'(1);
            if (port_mac_mem[pidx] == cur_reg.pkt_dst_mac)
            begin
                have_in_reg <= 1'b1;
                in_port_reg <= pidx;
                in_ip_reg   <= port_ip_mem[pidx];
            end
            if (port_ip_mem[pidx] == cur_reg.pkt_dst_ip)
            begin
                to_router_reg <= 1'b1;
            end
        end
        else if (state_reg == ST_ROUTES && !routes_done)
        begin
            ri_reg <= ri_reg + RCNT_W'(1);
            if (route_hit && (!matched_reg || rt_mask_mem[ridx] >= best_mask_reg))
            begin
                matched_reg   <= 1'b1;
                best_mask_reg <= rt_mask_mem[ridx];
                best_port_reg <= rt_port_mem[ridx];
                best_gw_reg   <= rt_gw_mem[ridx];
                out_mac_reg   <= (32'(rt_port_mem[ridx]) < MAX_PORTS)
                    ? port_mac_mem[PORT_W'(rt_port_mem[ridx])] : 48'd0;
            end
            else if (route_hit)
            begin
                matched_reg <= 1'b1;
            end
        end
        if (take && !is_classify)
        begin
            rsp_reg <= '0;
        end
        else if (state_reg == ST_OUT && out_slot_free)
        begin
            rsp_reg <= rsp_comb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((take && !is_classify) || (state_reg == ST_OUT && out_slot_free))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == ST_IDLE) else $error("request taken while busy");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_slot_free) |=> rsp_valid) else $error("result lost");
    a_no_in_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUTES) |-> have_in_reg) else $error("route scan without inbound");
endmodule
`default_nettype wire

// ===== hw/rtl/ipv4_forwarding_decision_lpm.sv =====
// Top level of the IPv4 forwarding decision block with longest-prefix match.
`default_nettype none
// Each transaction on req is a table write, a header to classify or an ignored action;
// each yields exactly one result transaction on rsp, in order. A classify transaction
// scans the interface table one entry a cycle and then, if the packet is not for the
// router, the routing table one route a cycle, and holds the engine until its result is
// loaded into the result register. A dropped header skips the route scan. A two-entry
// queue in front of the engine takes new transactions while the engine works, and the
// result register lets the next classify start while a result waits. Counts above the
// table sizes saturate. Configuration writes (index 0 interface_count, 1 route_count)
// are accepted every cycle and should only be made while the block is idle.
module ipv4_forwarding_decision_lpm (
    input wire logic clk,
    input wire logic rst_n,
    ipv4fwd_req_if.sink   req,
    ipv4fwd_rsp_if.source rsp,
    ipv4fwd_cfg_if.sink   cfg
);
    import ipv4fwd_pkg::*;

    logic [2:0] if_count_reg;
    logic [4:0] rt_count_reg;
    logic [PCNT_W-1:0] nif;
    logic [RCNT_W-1:0] nrt;
    logic q_valid, q_ready;
    req_t q_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if_count_reg <= '0;
            rt_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_IF_COUNT)
            begin
                if_count_reg <= cfg.wdata[2:0];
            end
            else
            begin
                rt_count_reg <= cfg.wdata[4:0];
            end
        end
    end

    // Saturate the counts at the table sizes.
    assign nif = (32'(if_count_reg) > MAX_PORTS)  ? PCNT_W'(MAX_PORTS)  : PCNT_W'(if_count_reg);
    assign nrt = (32'(rt_count_reg) > MAX_ROUTES) ? RCNT_W'(MAX_ROUTES) : RCNT_W'(rt_count_reg);

    ipv4fwd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    ipv4fwd_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_data),
        .nif(nif), .nrt(nrt),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data)
    );

    a_cfg_if: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.index == REG_IF_COUNT) |=> if_count_reg == $past(cfg.wdata[2:0]))
        else $error("interface count not written");
    a_nif_sat: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nif) <= MAX_PORTS) else $error("interface count not saturated");
    a_nrt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nrt) <= MAX_ROUTES) else $error("route count not saturated");
endmodule
`default_nettype wire

// ===== tb/tb_ipv4_forwarding_decision_lpm.sv =====
// Self-checking testbench for the IPv4 forwarding decision block with longest-prefix match.
module tb_ipv4_forwarding_decision_lpm;
    import ipv4fwd_pkg::*;

    // The pause before a register write and the quiet time at the end are sized
    // with margin to outlast the longest classify.
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 250;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        req_t        item;
        logic        typed;
        rsp_t        answer;
        logic        reg_index;
        logic [31:0] reg_value;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ipv4fwd_req_if req ();
    ipv4fwd_rsp_if rsp ();
    ipv4fwd_cfg_if cfg ();

    ipv4_forwarding_decision_lpm DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block's tables and count registers.
    logic [31:0] if_ip_shadow [MAX_PORTS];
    logic [47:0] if_mac_shadow [MAX_PORTS];
    logic [31:0] rt_prefix_shadow [MAX_ROUTES];
    logic [31:0] rt_mask_shadow [MAX_ROUTES];
    logic [31:0] rt_gw_shadow [MAX_ROUTES];
    logic [1:0]  rt_port_shadow [MAX_ROUTES];
    logic [2:0]  if_count_shadow;
    logic [4:0]  rt_count_shadow;

    // Decisions still owed by the block, oldest first.
    rsp_t pending_decisions [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int decisions_seen [8];
    int quiet_cycles = 0;

    stim_row_t directed [];

    // Predicts the result of one transaction and applies its table writes.
    function automatic rsp_t predict_decision(req_t r);
        rsp_t        o;
        bit          have_in, to_router, hit, tcp_udp, host_unr;
        logic [1:0]  in_port, best_port;
        logic [31:0] best_mask, best_gw, m;
        int          nif, nrt;
        o = '0;
        case (action_t'(r.action))
            ACT_WR_IF:
            begin
                if (r.entry_index < MAX_PORTS)
                begin
                    if_ip_shadow[r.entry_index[PORT_W-1:0]]  = r.entry_ip;
                    if_mac_shadow[r.entry_index[PORT_W-1:0]] = r.entry_mac;
                end
            end
            ACT_WR_ROUTE:
            begin
                rt_prefix_shadow[r.entry_index] = r.entry_ip;
                rt_mask_shadow[r.entry_index]   = r.entry_mask;
                rt_gw_shadow[r.entry_index]     = r.entry_gateway;
                rt_port_shadow[r.entry_index]   = r.entry_port;
            end
            ACT_CLASSIFY:
            begin
                nif = (if_count_shadow > MAX_PORTS) ? MAX_PORTS : if_count_shadow;
                nrt = (rt_count_shadow > MAX_ROUTES) ? MAX_ROUTES : rt_count_shadow;
                have_in = 0;
                to_router = 0;
                hit = 0;
                in_port = '0;
                best_port = '0;
                best_mask = '0;
                best_gw = '0;
                // The last interface whose MAC matches is the inbound one.
                for (int i = 0; i < nif; i++)
                begin
                    if (if_mac_shadow[i] == r.pkt_dst_mac)
                    begin
                        have_in = 1;
                        in_port = i[1:0];
                    end
                    if (if_ip_shadow[i] == r.pkt_dst_ip)
                        to_router = 1;
                end
                if (!have_in)
                    o.decision = DEC_DROP;
                else
                begin
                    o.inbound_port = in_port;
                    tcp_udp = to_router &&
                              (r.pkt_proto == PROTO_TCP || r.pkt_proto == PROTO_UDP);
                    host_unr = to_router && if_ip_shadow[in_port] != r.pkt_dst_ip;
                    // The numerically larger mask wins; on equal masks the later route wins.
                    if (!to_router)
                    begin
                        for (int i = 0; i < nrt; i++)
                        begin
                            m = rt_mask_shadow[i];
                            if ((m & rt_prefix_shadow[i]) == (m & r.pkt_dst_ip))
                            begin
                                if (!hit || m >= best_mask)
                                begin
                                    best_mask = m;
                                    best_port = rt_port_shadow[i];
                                    best_gw   = rt_gw_shadow[i];
                                end
                                hit = 1;
                            end
                        end
                    end
                    if (tcp_udp)
                    begin
                        o.decision = DEC_PORT_UNR;
                        o.reply_src_ip = r.pkt_dst_ip;
                    end
                    else if (!to_router && !hit)
                    begin
                        o.decision = DEC_NET_UNR;
                        o.reply_src_ip = r.pkt_dst_ip;
                    end
                    else if (host_unr)
                    begin
                        o.decision = DEC_HOST_UNR;
                        o.reply_src_ip = r.pkt_dst_ip;
                    end
                    else if (to_router && r.pkt_proto == PROTO_ICMP &&
                             r.pkt_icmp_kind == ICMP_ECHO_REQ)
                    begin
                        o.decision = DEC_ECHO;
                        o.reply_src_ip = if_ip_shadow[in_port];
                    end
                    else if (!to_router)
                    begin
                        // A TTL of zero or one expires here rather than wrapping.
                        if (r.pkt_ttl <= 8'd1)
                        begin
                            o.decision = DEC_TTL_EXC;
                            o.reply_src_ip = r.pkt_dst_ip;
                        end
                        else
                        begin
                            o.decision = DEC_FWD;
                            o.outbound_port = best_port;
                            o.next_hop_ip = (best_gw != 0) ? best_gw : r.pkt_dst_ip;
                            o.outbound_mac = if_mac_shadow[best_port];
                            o.new_ttl = r.pkt_ttl - 8'd1;
                        end
                    end
                    else
                        o.decision = DEC_ACK;
                end
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // Every field starts fully random so that unused fields toggle every bit.
    function automatic req_t noise_item();
        req_t r;
        r.action        = 2'($urandom);
        r.entry_index   = 4'($urandom);
        r.entry_ip      = $urandom;
        r.entry_mask    = $urandom;
        r.entry_gateway = $urandom;
        r.entry_port    = 2'($urandom);
        r.entry_mac     = rand48();
        r.pkt_dst_mac   = rand48();
        r.pkt_dst_ip    = $urandom;
        r.pkt_proto     = 8'($urandom);
        r.pkt_icmp_kind = 8'($urandom);
        r.pkt_ttl       = 8'($urandom);
        return r;
    endfunction

    function automatic req_t if_write(int idx, logic [31:0] ip, logic [47:0] mac);
        req_t r;
        r = noise_item();
        r.action = ACT_WR_IF;
        r.entry_index = 4'(idx);
        r.entry_ip = ip;
        r.entry_mac = mac;
        return r;
    endfunction

    function automatic req_t route_write(int idx, logic [31:0] prefix, logic [31:0] mask,
                                         logic [31:0] gw, logic [1:0] port);
        req_t r;
        r = noise_item();
        r.action = ACT_WR_ROUTE;
        r.entry_index = 4'(idx);
        r.entry_ip = prefix;
        r.entry_mask = mask;
        r.entry_gateway = gw;
        r.entry_port = port;
        return r;
    endfunction

    function automatic req_t header(logic [47:0] mac, logic [31:0] ip, logic [7:0] proto,
                                    logic [7:0] msg_kind, logic [7:0] ttl);
        req_t r;
        r = noise_item();
        r.action = ACT_CLASSIFY;
        r.pkt_dst_mac = mac;
        r.pkt_dst_ip = ip;
        r.pkt_proto = proto;
        r.pkt_icmp_kind = msg_kind;
        r.pkt_ttl = ttl;
        return r;
    endfunction

    function automatic rsp_t answer(decision_t dec, logic [1:0] in_port, logic [31:0] src);
        rsp_t o;
        o = '0;
        o.decision = dec;
        o.inbound_port = in_port;
        o.reply_src_ip = src;
        return o;
    endfunction

    // Random transaction biased toward headers that reach deep into the lookup:
    // MACs of known interfaces and addresses inside the programmed prefixes.
    function automatic req_t random_item();
        req_t r;
        int   pick, k;
        pick = $urandom_range(99);
        r = noise_item();
        if (pick < 8)
        begin
            r = if_write($urandom_range(MAX_PORTS - 1),
                         ($urandom_range(1)) ? {8'd10, 16'($urandom), 8'd1} : $urandom,
                         rand48());
        end
        else if (pick < 18)
        begin
            k = $urandom_range(MAX_ROUTES - 1);
            r = route_write(k, $urandom,
                            ($urandom_range(9) == 0) ? $urandom
                                                     : prefix_mask($urandom_range(32)),
                            ($urandom_range(1)) ? 32'h0 : $urandom, 2'($urandom));
        end
        else if (pick < 24)
        begin
            // Ignored action or an interface write to a slot past the table.
            if ($urandom_range(1))
                r.action = ACT_NONE;
            else
            begin
                r.action = ACT_WR_IF;
                r.entry_index = 4'($urandom_range(15, MAX_PORTS));
            end
        end
        else
        begin
            r.action = ACT_CLASSIFY;
            if ($urandom_range(99) < 85)
                r.pkt_dst_mac = if_mac_shadow[$urandom_range(MAX_PORTS - 1)];
            pick = $urandom_range(99);
            if (pick < 25)
                r.pkt_dst_ip = if_ip_shadow[$urandom_range(MAX_PORTS - 1)];
            else if (pick < 85)
            begin
                k = $urandom_range(MAX_ROUTES - 1);
                r.pkt_dst_ip = (rt_prefix_shadow[k] & rt_mask_shadow[k]) |
                               (32'($urandom) & ~rt_mask_shadow[k]);
            end
            case ($urandom_range(4))
                0: r.pkt_proto = PROTO_TCP;
                1: r.pkt_proto = PROTO_UDP;
                2, 3: r.pkt_proto = PROTO_ICMP;
                default: r.pkt_proto = 8'($urandom);
            endcase
            if ($urandom_range(1))
                r.pkt_icmp_kind = ICMP_ECHO_REQ;
            case ($urandom_range(5))
                0: r.pkt_ttl = 8'd0;
                1: r.pkt_ttl = 8'd1;
                2: r.pkt_ttl = 8'd2;
                3: r.pkt_ttl = 8'd255;
                default: r.pkt_ttl = 8'($urandom);
            endcase
        end
        return r;
    endfunction

    task automatic wait_until_drained();
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    // Sends one transaction. The valid line stays high between back-to-back
    // transactions and is only lowered when the sender takes a gap.
    task automatic send_item(req_t r, logic typed, rsp_t fixed);
        rsp_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = predict_decision(r);
        pending_decisions.push_back(typed ? fixed : predicted);
        items_sent++;
    endtask

    // Register writes only happen with the block idle.
    task automatic write_register(logic idx, logic [31:0] value);
        req.valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_IF_COUNT)
            if_count_shadow = value[2:0];
        else
            rt_count_shadow = value[4:0];
    endtask

    // Result side: random back-pressure and an in-order comparison with the
    // oldest pending decision.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("unexpected result transaction, decision %0d", rsp.data.decision);
                mismatches++;
            end
            else
            begin
                rsp_t e;
                e = pending_decisions.pop_front();
                decisions_seen[e.decision]++;
                if (rsp.data.decision !== e.decision)
                begin
                    $error("decision: expected %0d, got %0d", e.decision, rsp.data.decision);
                    mismatches++;
                end
                if (rsp.data.inbound_port !== e.inbound_port)
                begin
                    $error("inbound_port: expected %0d, got %0d",
                           e.inbound_port, rsp.data.inbound_port);
                    mismatches++;
                end
                if (rsp.data.outbound_port !== e.outbound_port)
                begin
                    $error("outbound_port: expected %0d, got %0d",
                           e.outbound_port, rsp.data.outbound_port);
                    mismatches++;
                end
                if (rsp.data.next_hop_ip !== e.next_hop_ip)
                begin
                    $error("next_hop_ip: expected %h, got %h",
                           e.next_hop_ip, rsp.data.next_hop_ip);
                    mismatches++;
                end
                if (rsp.data.outbound_mac !== e.outbound_mac)
                begin
                    $error("outbound_mac: expected %h, got %h",
                           e.outbound_mac, rsp.data.outbound_mac);
                    mismatches++;
                end
                if (rsp.data.reply_src_ip !== e.reply_src_ip)
                begin
                    $error("reply_src_ip: expected %h, got %h",
                           e.reply_src_ip, rsp.data.reply_src_ip);
                    mismatches++;
                end
                if (rsp.data.new_ttl !== e.new_ttl)
                begin
                    $error("new_ttl: expected %0d, got %0d", e.new_ttl, rsp.data.new_ttl);
                    mismatches++;
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("[ipv4_forwarding_decision_lpm] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] if_counts [6];
        logic [4:0] rt_counts [6];

        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_IF_COUNT;
        cfg.wdata <= '0;
        if_count_shadow = '0;
        rt_count_shadow = '0;
        foreach (decisions_seen[i])
            decisions_seen[i] = 0;

        // Directed table. Interface 3 holds the all-ones MAC, interface 0 the
        // all-zero address and MAC. Routes: a default route through a gateway,
        // a /16, two equal /24s where the later one must win, and a host route.
        directed = new[28];
        foreach (directed[i])
        begin
            directed[i].kind = ROW_ITEM;
            directed[i].typed = 1'b0;
            directed[i].answer = '0;
            directed[i].reg_index = REG_IF_COUNT;
            directed[i].reg_value = '0;
        end
        directed[0].item  = if_write(0, 32'h0, 48'h0);
        directed[1].item  = if_write(1, 32'h0A00_0101, 48'h0200_0000_0001);
        directed[2].item  = if_write(2, 32'h0A00_0201, 48'h0200_0000_0002);
        directed[3].item  = if_write(3, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF);
        directed[4].item  = if_write(9, 32'hDEAD_BEEF, 48'h0200_0000_0001);
        directed[5].item  = noise_item();
        directed[5].item.action = ACT_NONE;
        directed[6].item  = route_write(0, 32'h0, 32'h0, 32'hC0A8_0001, 2'd0);
        directed[7].item  = route_write(1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 2'd1);
        directed[8].item  = route_write(2, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_0203, 2'd2);
        directed[9].item  = route_write(3, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0, 2'd3);
        directed[10].item = route_write(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        // Writes and the ignored action are acknowledged with an all-zero result.
        for (int i = 0; i <= 10; i++)
        begin
            directed[i].typed = 1'b1;
            directed[i].answer = answer(DEC_ACK, 2'd0, 32'h0);
        end
        // With no interfaces in use every header is dropped.
        directed[11].item = header(48'h0, 32'h0, PROTO_ICMP, ICMP_ECHO_REQ, 8'd64);
        directed[11].typed = 1'b1;
        directed[11].answer = answer(DEC_DROP, 2'd0, 32'h0);
        directed[12].kind = ROW_CFG;
        directed[12].reg_index = REG_IF_COUNT;
        directed[12].reg_value = 32'd4;
        directed[13].kind = ROW_CFG;
        directed[13].reg_index = REG_ROUTE_COUNT;
        directed[13].reg_value = 32'd5;
        directed[14].item = header(48'h0200_0000_0009, 32'h0A01_0203, PROTO_TCP, 8'd0, 8'd9);
        directed[14].typed = 1'b1;
        directed[14].answer = answer(DEC_DROP, 2'd0, 32'h0);
        directed[15].item = header(48'h0200_0000_0001, 32'h0A00_0101, PROTO_TCP, 8'd0, 8'd9);
        directed[15].typed = 1'b1;
        directed[15].answer = answer(DEC_PORT_UNR, 2'd1, 32'h0A00_0101);
        directed[16].item = header(48'h0200_0000_0001, 32'h0A00_0201, PROTO_UDP, 8'd0, 8'd9);
        directed[17].item = header(48'h0200_0000_0001, 32'h0A00_0101, PROTO_ICMP,
                                   ICMP_ECHO_REQ, 8'd9);
        directed[17].typed = 1'b1;
        directed[17].answer = answer(DEC_ECHO, 2'd1, 32'h0A00_0101);
        directed[18].item = header(48'h0200_0000_0001, 32'h0A00_0201, PROTO_ICMP,
                                   ICMP_ECHO_REQ, 8'd9);
        directed[19].item = header(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFE, PROTO_ICMP, 8'd0, 8'd9);
        directed[20].item = header(48'h0, 32'h0A01_0209, 8'hFF, 8'hFF, 8'd255);
        directed[21].item = header(48'h0, 32'h0A01_7777, PROTO_TCP, 8'd0, 8'd2);
        directed[22].item = header(48'h0, 32'h0A01_0209, PROTO_UDP, 8'd0, 8'd1);
        directed[23].item = header(48'h0, 32'h0A01_0209, PROTO_UDP, 8'd0, 8'd0);
        directed[24].item = header(48'h0, 32'hFFFF_FFFF, PROTO_ICMP, 8'd0, 8'd100);
        directed[25].item = header(48'h0200_0000_0002, 32'h0800_0808, PROTO_ICMP, 8'd0, 8'd30);
        directed[26].kind = ROW_CFG;
        directed[26].reg_index = REG_ROUTE_COUNT;
        directed[26].reg_value = 32'd0;
        // No routes in use: a packet not for the router is net unreachable.
        directed[27].item = header(48'h0200_0000_0002, 32'h0800_0808, PROTO_ICMP, 8'd0, 8'd30);
        directed[27].typed = 1'b1;
        directed[27].answer = answer(DEC_NET_UNR, 2'd2, 32'h0800_0808);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].reg_index, directed[i].reg_value);
            else
                send_item(directed[i].item, directed[i].typed, directed[i].answer);
        end

        // Fill every table slot so that any count setting reads written entries.
        for (int i = 0; i < MAX_PORTS; i++)
            send_item(if_write(i, {8'd10, 8'($urandom), 8'(i), 8'd1}, rand48()), 1'b0, '0);
        for (int i = 0; i < MAX_ROUTES; i++)
            send_item(route_write(i, $urandom, prefix_mask($urandom_range(32)),
                                  ($urandom_range(1)) ? 32'h0 : $urandom, 2'($urandom)),
                      1'b0, '0);

        // Random phases: count settings include both extremes and the
        // saturating values; the idling pattern changes every two phases.
        if_counts = '{3'd4, 3'd7, 3'd0, 3'd1, 3'd4, 3'd2};
        rt_counts = '{5'd16, 5'd31, 5'd0, 5'd3, 5'd16, 5'd31};
        for (int p = 0; p < 6; p++)
        begin
            write_register(REG_IF_COUNT, 32'(if_counts[p]));
            write_register(REG_ROUTE_COUNT, 32'(rt_counts[p]));
            case (p / 2)
                0: begin tx_idle_pct = 37; rx_idle_pct = 47; end
                1: begin tx_idle_pct = 47; rx_idle_pct = 37; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Once in the first phase the sender holds off until the block
                // has returned everything, then resumes.
                if (p == 0 && n == PHASE_ITEMS / 2)
                begin
                    req.valid <= 1'b0;
                    wait_until_drained();
                end
                send_item(random_item(), 1'b0, '0);
            end
        end

        req.valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d transactions sent; decisions ack %0d drop %0d port-unr %0d net-unr %0d",
                 items_sent, decisions_seen[DEC_ACK], decisions_seen[DEC_DROP],
                 decisions_seen[DEC_PORT_UNR], decisions_seen[DEC_NET_UNR]);
        $display("host-unr %0d echo %0d forward %0d ttl-exceeded %0d; %0d mismatches",
                 decisions_seen[DEC_HOST_UNR], decisions_seen[DEC_ECHO],
                 decisions_seen[DEC_FWD], decisions_seen[DEC_TTL_EXC], mismatches);
        if (mismatches == 0)
            $display("[ipv4_forwarding_decision_lpm] OK");
        else
            $display("[ipv4_forwarding_decision_lpm] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ipv4fwd_pkg.sv
hw/rtl/ipv4fwd_if.sv
hw/rtl/ipv4fwd_queue.sv
hw/rtl/ipv4fwd_engine.sv
hw/rtl/ipv4_forwarding_decision_lpm.sv
tb/tb_ipv4_forwarding_decision_lpm.sv
